// ===== hw/rtl/lcs_pkg.sv =====
// Shared constants, cadence ROM, status codes and command type for the LED cadence sequencer.
package lcs_pkg;

    localparam int NUM_LEDS      = 8;
    localparam int NUM_CADENCES  = 9;
    localparam int MAX_ENTRIES   = 4;

    localparam int OP_W     = 1;
    localparam int IDX_W    = 8;
    localparam int CAD_W    = 4;
    localparam int DUR_W    = 24;
    localparam int TICK_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEVELS_W = 8;
    localparam int POS_W    = 2;
    localparam int CNT_W    = 3;
    localparam int TIMER_W  = 13;

    localparam logic [TICK_W-1:0] TICK_MS_RESET = 8'd20;

    localparam logic [OP_W-1:0] OP_TICK = 1'b0;
    localparam logic [OP_W-1:0] OP_SET  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_LED      = 2'd1,
        ST_BAD_CADENCE = 2'd2
    } t_status;

    // entries per cadence
    localparam logic [CNT_W-1:0] CAD_COUNT [NUM_CADENCES] = '{
        3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2
    };

    localparam logic CAD_ON [NUM_CADENCES][MAX_ENTRIES] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0}
    };

    localparam logic [TIMER_W-1:0] CAD_MS [NUM_CADENCES][MAX_ENTRIES] = '{
        '{13'd100, 13'd0,    13'd0,  13'd0},
        '{13'd100, 13'd0,    13'd0,  13'd0},
        '{13'd980, 13'd20,   13'd0,  13'd0},
        '{13'd500, 13'd500,  13'd0,  13'd0},
        '{13'd20,  13'd20,   13'd0,  13'd0},
        '{13'd20,  13'd980,  13'd0,  13'd0},
        '{13'd20,  13'd20,   13'd20, 13'd940},
        '{13'd250, 13'd5000, 13'd0,  13'd0},
        '{13'd250, 13'd250,  13'd0,  13'd0}
    };

    typedef struct packed {
        logic              tick;
        logic              set;
        logic [IDX_W-1:0]  led_index;
        logic [CAD_W-1:0]  cadence;
        logic [DUR_W-1:0]  duration;
        logic              endless;
    } t_led_cmd;

endpackage

// ===== hw/rtl/lcs_if.sv =====
// Valid/ready channel interfaces for request and result beats.
interface lcs_in_if;
    logic                        valid;
    logic                        ready;
    logic [lcs_pkg::OP_W-1:0]    operation;
    logic [lcs_pkg::IDX_W-1:0]   led_index;
    logic [lcs_pkg::CAD_W-1:0]   cadence_select;
    logic [lcs_pkg::DUR_W-1:0]   duration;
    logic                        duration_forever;

    modport source (
        output valid, operation, led_index, cadence_select, duration, duration_forever,
        input  ready
    );
    modport sink (
        input  valid, operation, led_index, cadence_select, duration, duration_forever,
        output ready
    );
endinterface

interface lcs_out_if;
    logic                           valid;
    logic                           ready;
    logic [lcs_pkg::STATUS_W-1:0]   status;
    logic [lcs_pkg::LEVELS_W-1:0]   led_levels;

    modport source (
        output valid, status, led_levels,
        input  ready
    );
    modport sink (
        input  valid, status, led_levels,
        output ready
    );
endinterface

// ===== hw/rtl/lcs_cadence_bank.sv =====
// Nine cadence sequencers: position, countdown timer and level per cadence.
module lcs_cadence_bank (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tick,
    input  logic [lcs_pkg::TICK_W-1:0]        i_tick_ms,
    output logic [lcs_pkg::NUM_CADENCES-1:0]  o_level
);

    logic [lcs_pkg::POS_W-1:0]   r_pos   [lcs_pkg::NUM_CADENCES];
    logic [lcs_pkg::TIMER_W-1:0] r_timer [lcs_pkg::NUM_CADENCES];
    logic [lcs_pkg::NUM_CADENCES-1:0] r_level;

    logic [lcs_pkg::POS_W-1:0]   n_pos   [lcs_pkg::NUM_CADENCES];
    logic [lcs_pkg::TIMER_W-1:0] n_timer [lcs_pkg::NUM_CADENCES];
    logic [lcs_pkg::NUM_CADENCES-1:0] n_level;

    logic [lcs_pkg::TIMER_W-1:0] w_step;

    assign w_step = lcs_pkg::TIMER_W'(i_tick_ms);

    always_comb begin
        logic [lcs_pkg::CNT_W-1:0] p;
        p = '0;
        for (int i = 0; i < lcs_pkg::NUM_CADENCES; i++) begin
            n_pos[i]   = r_pos[i];
            n_timer[i] = r_timer[i];
            n_level[i] = r_level[i];
            if (i_tick) begin
                if (r_timer[i] == '0) begin
                    p = lcs_pkg::CNT_W'(r_pos[i]) + lcs_pkg::CNT_W'(1);
                    if (p >= lcs_pkg::CAD_COUNT[i]) begin
                        p = '0;
                    end
                    n_pos[i]   = p[lcs_pkg::POS_W-1:0];
                    n_timer[i] = lcs_pkg::CAD_MS[i][p[lcs_pkg::POS_W-1:0]];
                    n_level[i] = lcs_pkg::CAD_ON[i][p[lcs_pkg::POS_W-1:0]];
                end else if (r_timer[i] > w_step) begin
                    n_timer[i] = r_timer[i] - w_step;
                end else begin
                    n_timer[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lcs_pkg::NUM_CADENCES; i++) begin
                r_pos[i]   <= '0;
                r_timer[i] <= '0;
            end
            r_level <= '0;
        end else begin
            for (int i = 0; i < lcs_pkg::NUM_CADENCES; i++) begin
                r_pos[i]   <= n_pos[i];
                r_timer[i] <= n_timer[i];
            end
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

// ===== hw/rtl/lcs_led_bank.sv =====
// Per-LED binding, remaining duration and lit state.
module lcs_led_bank (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcs_pkg::t_led_cmd                 i_cmd,
    input  logic [lcs_pkg::TICK_W-1:0]        i_tick_ms,
    input  logic [lcs_pkg::NUM_CADENCES-1:0]  i_pattern_level,
    output logic [lcs_pkg::NUM_LEDS-1:0]      o_lit_next
);

    logic [lcs_pkg::CAD_W-1:0] r_choice [lcs_pkg::NUM_LEDS];
    logic [lcs_pkg::DUR_W-1:0] r_time   [lcs_pkg::NUM_LEDS];
    logic [lcs_pkg::NUM_LEDS-1:0] r_endless;
    logic [lcs_pkg::NUM_LEDS-1:0] r_lit;

    logic [lcs_pkg::CAD_W-1:0] n_choice [lcs_pkg::NUM_LEDS];
    logic [lcs_pkg::DUR_W-1:0] n_time   [lcs_pkg::NUM_LEDS];
    logic [lcs_pkg::NUM_LEDS-1:0] n_endless;
    logic [lcs_pkg::NUM_LEDS-1:0] n_lit;

    logic [lcs_pkg::DUR_W-1:0] w_step;

    assign w_step = lcs_pkg::DUR_W'(i_tick_ms);

    always_comb begin
        for (int i = 0; i < lcs_pkg::NUM_LEDS; i++) begin
            n_choice[i]  = r_choice[i];
            n_time[i]    = r_time[i];
            n_endless[i] = r_endless[i];
            n_lit[i]     = r_lit[i];
            if (i_cmd.tick) begin
                if ((r_endless[i] || r_time[i] != '0) &&
                    r_choice[i] < lcs_pkg::CAD_W'(lcs_pkg::NUM_CADENCES)) begin
                    n_lit[i] = i_pattern_level[r_choice[i]];
                end else begin
                    n_lit[i] = 1'b0;
                end
                if (!r_endless[i]) begin
                    n_time[i] = (r_time[i] > w_step) ? r_time[i] - w_step : '0;
                end
            end else if (i_cmd.set && i_cmd.led_index == lcs_pkg::IDX_W'(i)) begin
                n_choice[i]  = i_cmd.cadence;
                n_time[i]    = i_cmd.duration;
                n_endless[i] = i_cmd.endless;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lcs_pkg::NUM_LEDS; i++) begin
                r_choice[i] <= '0;
                r_time[i]   <= '0;
            end
            r_endless <= '0;
            r_lit     <= '0;
        end else begin
            for (int i = 0; i < lcs_pkg::NUM_LEDS; i++) begin
                r_choice[i] <= n_choice[i];
                r_time[i]   <= n_time[i];
            end
            r_endless <= n_endless;
            r_lit     <= n_lit;
        end
    end

    assign o_lit_next = n_lit;

endmodule

// ===== hw/rtl/led_cadence_sequencer.sv =====
// Top level: input beat register, request check, LED and cadence banks, result register.
// Takes one request beat per clock while the result side is free and returns one result
// beat per request: the beat is captured in the input register, then the LED bank and
// all nine cadence sequencers update side by side and status and LED levels land in the
// result register. A tick beat refreshes every LED from its cadence's prior level, counts
// durations down by tick_ms and steps the cadences; a set beat with good status binds one
// LED, and every set beat reports status. Results stall only while the result register
// is held by the downstream side. The user must write tick_ms through i_cfg_we/i_cfg_wdata
// only while no beat is in flight; the block does not enforce it. tick_ms resets to 20.
module led_cadence_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lcs_pkg::TICK_W-1:0]  i_cfg_wdata,
    lcs_in_if.sink                      i_item,
    lcs_out_if.source                   o_result
);

    logic                         r_in_valid;
    logic [lcs_pkg::OP_W-1:0]     r_op;
    logic [lcs_pkg::IDX_W-1:0]    r_idx;
    logic [lcs_pkg::CAD_W-1:0]    r_cad;
    logic [lcs_pkg::DUR_W-1:0]    r_dur;
    logic                         r_endless;

    logic [lcs_pkg::TICK_W-1:0]   r_tick_ms;

    logic                         r_out_valid;
    lcs_pkg::t_status             r_status;
    logic [lcs_pkg::LEVELS_W-1:0] r_levels;

    logic                              w_advance;
    logic                              w_in_fire;
    lcs_pkg::t_status                  w_status;
    lcs_pkg::t_led_cmd                 w_cmd;
    logic [lcs_pkg::NUM_CADENCES-1:0]  w_pattern_level;
    logic [lcs_pkg::NUM_LEDS-1:0]      w_lit_next;
    logic [lcs_pkg::LEVELS_W-1:0]      w_levels;

    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign w_in_fire    = i_item.valid && i_item.ready;

    always_comb begin
        priority if (r_op == lcs_pkg::OP_SET &&
                     r_cad >= lcs_pkg::CAD_W'(lcs_pkg::NUM_CADENCES)) begin
            w_status = lcs_pkg::ST_BAD_CADENCE;
        end else if (r_op == lcs_pkg::OP_SET &&
                     r_idx >= lcs_pkg::IDX_W'(lcs_pkg::NUM_LEDS)) begin
            w_status = lcs_pkg::ST_NO_LED;
        end else begin
            w_status = lcs_pkg::ST_OK;
        end
    end

    always_comb begin
        w_cmd.tick      = w_advance && r_op == lcs_pkg::OP_TICK;
        w_cmd.set       = w_advance && r_op == lcs_pkg::OP_SET && w_status == lcs_pkg::ST_OK;
        w_cmd.led_index = r_idx;
        w_cmd.cadence   = r_cad;
        w_cmd.duration  = r_dur;
        w_cmd.endless   = r_endless;
    end

    lcs_cadence_bank u_cadence_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (w_cmd.tick),
        .i_tick_ms (r_tick_ms),
        .o_level   (w_pattern_level)
    );

    lcs_led_bank u_led_bank (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_tick_ms       (r_tick_ms),
        .i_pattern_level (w_pattern_level),
        .o_lit_next      (w_lit_next)
    );

    // only LEDs below LEVELS_W are visible
    for (genvar b = 0; b < lcs_pkg::LEVELS_W; b++) begin : g_levels
        if (b < lcs_pkg::NUM_LEDS) begin : g_on
            assign w_levels[b] = w_lit_next[b];
        end else begin : g_off
            assign w_levels[b] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick_ms   <= lcs_pkg::TICK_MS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_tick_ms <= i_cfg_wdata;
            end
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op      <= i_item.operation;
            r_idx     <= i_item.led_index;
            r_cad     <= i_item.cadence_select;
            r_dur     <= i_item.duration;
            r_endless <= i_item.duration_forever;
        end
        if (w_advance) begin
            r_status <= w_status;
            r_levels <= w_levels;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_status;
    assign o_result.led_levels = r_levels;

endmodule
